/* src/isotp_pkg.sv */
// Shared types, constants and a helper function for the segmented CAN transport sender.
// Used by isotp_csr and isotp_segmented_sender_top.
`default_nettype none

package isotp_pkg;

   localparam int BUFFER_BYTES_DEF = 256;

   localparam logic [10:0] LISTEN_ID_RST   = 11'd2015;
   localparam logic [10:0] REPLY_ID_RST    = 11'd2024;
   localparam logic [10:0] TESTER_BASE_RST = 11'h7E0;
   localparam logic [15:0] FC_TIMEOUT_RST  = 16'd1000;

   localparam logic [10:0] ALT_LISTEN_ID  = 11'h7E0;
   localparam logic [10:0] FC_ID_MASK     = 11'h7F0;

   localparam logic [3:0] PCI_SINGLE      = 4'h0;
   localparam logic [3:0] PCI_FIRST       = 4'h1;
   localparam logic [3:0] PCI_CONSECUTIVE = 4'h2;
   localparam logic [3:0] PCI_FLOW        = 4'h3;

   localparam logic [3:0] FS_CONTINUE = 4'h0;
   localparam logic [3:0] FS_WAIT     = 4'h1;

   localparam logic [7:0] STMIN_MAX = 8'h7F;

   localparam logic [12:0] DIV7_RECIP = 13'd4682;
   localparam int          DIV7_SHIFT = 15;

   typedef enum logic [1:0] {
      OP_POLL,
      OP_RECEIVE,
      OP_LOAD,
      OP_SEND
   } op_type;

   typedef enum logic [1:0] {
      REG_LISTEN_ID,
      REG_REPLY_ID,
      REG_TESTER_BASE,
      REG_FC_TIMEOUT
   } reg_type;

   typedef struct packed {
      logic [10:0] listen_id;
      logic [10:0] reply_id;
      logic [10:0] tester_base;
      logic [15:0] fc_timeout;
   } cfg_type;

   // Number of consecutive frames for a length, that is length / 7, exact for 12-bit lengths.
   function automatic logic [9:0] frames_for_length(input logic [11:0] len);
      logic [24:0] prod;
      prod = 25'(len) * 25'(DIV7_RECIP);
      return prod[24:DIV7_SHIFT];
   endfunction

endpackage

`default_nettype wire

/* src/isotp_csr.sv */
// Configuration registers of the segmented CAN transport sender behind an APB-style port.
// Depends on isotp_pkg for the register map, reset values and the cfg_type struct.
`default_nettype none

module isotp_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [3:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready,
   output isotp_pkg::cfg_type     cfg
);

   isotp_pkg::cfg_type cfg_ff;
   isotp_pkg::reg_type reg_idx;
   logic               wr_en;

   assign reg_idx    = isotp_pkg::reg_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.listen_id   <= isotp_pkg::LISTEN_ID_RST;
         cfg_ff.reply_id    <= isotp_pkg::REPLY_ID_RST;
         cfg_ff.tester_base <= isotp_pkg::TESTER_BASE_RST & isotp_pkg::FC_ID_MASK;
         cfg_ff.fc_timeout  <= isotp_pkg::FC_TIMEOUT_RST;
      end else if (wr_en) begin
         case (reg_idx)
            isotp_pkg::REG_LISTEN_ID: begin
               cfg_ff.listen_id <= csr_pwdata[10:0];
            end
            isotp_pkg::REG_REPLY_ID: begin
               cfg_ff.reply_id <= csr_pwdata[10:0];
            end
            isotp_pkg::REG_TESTER_BASE: begin
               cfg_ff.tester_base <= csr_pwdata[10:0] & isotp_pkg::FC_ID_MASK;
            end
            isotp_pkg::REG_FC_TIMEOUT: begin
               cfg_ff.fc_timeout <= csr_pwdata[15:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         isotp_pkg::REG_LISTEN_ID:   csr_prdata = {21'd0, cfg_ff.listen_id};
         isotp_pkg::REG_REPLY_ID:    csr_prdata = {21'd0, cfg_ff.reply_id};
         isotp_pkg::REG_TESTER_BASE: csr_prdata = {21'd0, cfg_ff.tester_base};
         isotp_pkg::REG_FC_TIMEOUT:  csr_prdata = {16'd0, cfg_ff.fc_timeout};
         default:                    csr_prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

/* src/isotp_segmented_sender_top.sv */
// Top level of the segmented CAN transport sender: payload memory, transfer state and words.
// Depends on isotp_pkg and isotp_csr.
// Loads, received frames and polls that send nothing finish at the accepting edge;
// a delivered request is shown on rsp the next cycle. For a frame word (n = 0..7 payload
// bytes), the payload memory gives one byte per cycle; the word goes to rsp when rsp is free.
// One item is taken per cycle while rsp is not stalled; none while a frame is being built.
// Reset: synchronous; clears the transfer state, the output valid and the configuration to
// its defaults. Payload memory contents are undefined until written.
`default_nettype none

module isotp_segmented_sender_top #(
   parameter int BUFFER_BYTES = isotp_pkg::BUFFER_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [31:0] req_now_ms,
   input  wire logic [10:0] req_can_id,
   input  wire logic [3:0]  req_frame_len,
   input  wire logic [63:0] req_frame_data,
   input  wire logic [7:0]  req_byte_index,
   input  wire logic [7:0]  req_payload_byte,
   input  wire logic [11:0] req_msg_length,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [10:0]      rsp_frame_id,
   output logic [63:0]      rsp_out_data,
   output logic [2:0]       rsp_request_len,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int AW    = $clog2(BUFFER_BYTES);
   localparam int LEN_W = $clog2(BUFFER_BYTES + 1);
   localparam int FR_W  = $clog2(BUFFER_BYTES / 7 + 1);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WAIT_FC,
      PH_SENDING
   } phase_type;

   isotp_pkg::cfg_type cfg;

   isotp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   logic [7:0] store_ff [BUFFER_BYTES];

   phase_type         phase_ff, phase_in;
   logic [LEN_W-1:0]  total_ff, total_in;
   logic [LEN_W-1:0]  offset_ff, offset_in;
   logic [3:0]        seq_ff, seq_in;
   logic [FR_W-1:0]   frames_ff, frames_in;
   logic [6:0]        sep_ff, sep_in;
   logic [31:0]       next_ff, next_in;
   logic [31:0]       deadline_ff, deadline_in;

   logic              busy_ff;
   logic [2:0]        cnt_ff;
   logic [2:0]        n_ff;
   logic [2:0]        pos_ff;
   logic [LEN_W-1:0]  base_ff;
   logic [63:0]       frame_ff;
   logic              rd_vld_ff;
   logic [2:0]        rd_pos_ff;
   logic [7:0]        rd_data_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff;
   logic [10:0]       rsp_frame_id_ff;
   logic [63:0]       rsp_out_data_ff;
   logic [2:0]        rsp_request_len_ff;

   logic              out_free;
   logic              accept;
   isotp_pkg::op_type op;

   logic              start_frame;
   logic [2:0]        n_start;
   logic [2:0]        pos_start;
   logic [LEN_W-1:0]  base_start;
   logic [63:0]       hdr_start;
   logic              req_result;
   logic [63:0]       req_data;
   logic [2:0]        req_plen;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;

   logic [11:0]       len_clamp;
   logic [LEN_W-1:0]  remain;
   logic [2:0]        n_poll;
   logic [3:0]        len_eff;
   logic [2:0]        len_m1;
   logic [7:0]        b0;
   logic [7:0]        stmin;

   logic              issue;
   logic              done;
   logic [AW-1:0]     rd_addr;
   logic [63:0]       frame_merge;

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = busy_ff | ~out_free;
   assign accept    = req_valid & ~req_stall;
   assign op        = isotp_pkg::op_type'(req_operation);

   assign issue   = busy_ff & (cnt_ff != n_ff);
   assign done    = busy_ff & (cnt_ff == n_ff);
   assign rd_addr = AW'(base_ff + LEN_W'(cnt_ff));

   assign rsp_valid_in = (accept & req_result) | (done & out_free) | (rsp_valid_ff & rsp_stall);

   always_comb begin
      frame_merge = frame_ff;
      if (rd_vld_ff) begin
         frame_merge[rd_pos_ff*8 +: 8] = rd_data_ff;
      end
   end

   always_comb begin
      int k;
      phase_in    = phase_ff;
      total_in    = total_ff;
      offset_in   = offset_ff;
      seq_in      = seq_ff;
      frames_in   = frames_ff;
      sep_in      = sep_ff;
      next_in     = next_ff;
      deadline_in = deadline_ff;
      start_frame = 1'b0;
      n_start     = 3'd0;
      pos_start   = 3'd1;
      base_start  = '0;
      hdr_start   = 64'd0;
      req_result  = 1'b0;
      req_data    = 64'd0;
      req_plen    = 3'd0;
      mem_we      = 1'b0;
      mem_waddr   = AW'(req_byte_index);

      len_clamp = (req_msg_length > 12'(BUFFER_BYTES)) ? 12'(BUFFER_BYTES) : req_msg_length;
      remain    = (total_ff > offset_ff) ? total_ff - offset_ff : '0;
      n_poll    = (remain > LEN_W'(7)) ? 3'd7 : remain[2:0];
      len_eff   = (req_frame_len > 4'd8) ? 4'd8 : req_frame_len;
      len_m1    = 3'(len_eff - 4'd1);
      b0        = req_frame_data[7:0];
      stmin     = req_frame_data[23:16];

      case (op)
         isotp_pkg::OP_POLL: begin
            if (phase_ff == PH_WAIT_FC) begin
               if (req_now_ms >= deadline_ff) begin
                  phase_in  = PH_IDLE;
                  frames_in = '0;
               end
            end else if (phase_ff == PH_SENDING && frames_ff != '0
                         && req_now_ms >= next_ff) begin
               start_frame = 1'b1;
               n_start     = n_poll;
               pos_start   = 3'd1;
               base_start  = offset_ff;
               hdr_start   = {56'd0, isotp_pkg::PCI_CONSECUTIVE, seq_ff};
               offset_in   = offset_ff + LEN_W'(n_poll);
               seq_in      = seq_ff + 4'd1;
               frames_in   = frames_ff - FR_W'(1);
               next_in     = req_now_ms + 32'(sep_ff);
               if (frames_ff == FR_W'(1)) begin
                  phase_in = PH_IDLE;
               end
            end
         end
         isotp_pkg::OP_RECEIVE: begin
            if (req_frame_len != 4'd0) begin
               if ((req_can_id & isotp_pkg::FC_ID_MASK) == cfg.tester_base) begin
                  if (phase_ff == PH_WAIT_FC && b0[7:4] == isotp_pkg::PCI_FLOW) begin
                     if (b0[3:0] == isotp_pkg::FS_CONTINUE) begin
                        sep_in   = (req_frame_len >= 4'd3 && stmin <= isotp_pkg::STMIN_MAX) ?
                                   stmin[6:0] : 7'd0;
                        phase_in = PH_SENDING;
                        next_in  = req_now_ms;
                     end else if (b0[3:0] == isotp_pkg::FS_WAIT) begin
                        deadline_in = req_now_ms + 32'(cfg.fc_timeout);
                     end else begin
                        phase_in  = PH_IDLE;
                        frames_in = '0;
                     end
                  end
               end else if ((req_can_id == cfg.listen_id
                             || req_can_id == isotp_pkg::ALT_LISTEN_ID)
                            && b0[7:4] == isotp_pkg::PCI_SINGLE) begin
                  req_result = 1'b1;
                  req_plen   = (b0[3:0] > 4'(len_m1)) ? len_m1 : b0[2:0];
                  for (k = 0; k < 7; k++) begin
                     if (3'(k) < req_plen) begin
                        req_data[k*8 +: 8] = req_frame_data[(k+1)*8 +: 8];
                     end
                  end
               end
            end
         end
         isotp_pkg::OP_LOAD: begin
            mem_we = (32'(req_byte_index) < 32'(BUFFER_BYTES));
         end
         isotp_pkg::OP_SEND: begin
            start_frame = 1'b1;
            base_start  = '0;
            if (req_msg_length <= 12'd7) begin
               n_start   = req_msg_length[2:0];
               pos_start = 3'd1;
               hdr_start = {56'd0, isotp_pkg::PCI_SINGLE, req_msg_length[3:0]};
               phase_in  = PH_IDLE;
            end else begin
               n_start     = 3'd6;
               pos_start   = 3'd2;
               hdr_start   = {48'd0, len_clamp[7:0], isotp_pkg::PCI_FIRST, len_clamp[11:8]};
               phase_in    = PH_WAIT_FC;
               total_in    = LEN_W'(len_clamp);
               offset_in   = LEN_W'(6);
               seq_in      = 4'd1;
               frames_in   = FR_W'(isotp_pkg::frames_for_length(len_clamp));
               sep_in      = 7'd0;
               deadline_in = req_now_ms + 32'(cfg.fc_timeout);
            end
         end
         default: begin
            start_frame = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && mem_we) begin
         store_ff[mem_waddr] <= req_payload_byte;
      end
      if (issue) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         total_ff     <= '0;
         offset_ff    <= '0;
         seq_ff       <= 4'd0;
         frames_ff    <= '0;
         sep_ff       <= 7'd0;
         next_ff      <= 32'd0;
         deadline_ff  <= 32'd0;
         busy_ff      <= 1'b0;
         cnt_ff       <= 3'd0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff    <= issue;
         rsp_valid_ff <= rsp_valid_in;
         if (issue) begin
            cnt_ff    <= cnt_ff + 3'd1;
            rd_pos_ff <= pos_ff + cnt_ff;
         end
         if (busy_ff) begin
            frame_ff <= frame_merge;
         end

         if (accept) begin
            phase_ff    <= phase_in;
            total_ff    <= total_in;
            offset_ff   <= offset_in;
            seq_ff      <= seq_in;
            frames_ff   <= frames_in;
            sep_ff      <= sep_in;
            next_ff     <= next_in;
            deadline_ff <= deadline_in;
            if (start_frame) begin
               busy_ff  <= 1'b1;
               cnt_ff   <= 3'd0;
               n_ff     <= n_start;
               pos_ff   <= pos_start;
               base_ff  <= base_start;
               frame_ff <= hdr_start;
            end
            if (req_result) begin
               rsp_kind_ff        <= 1'b1;
               rsp_frame_id_ff    <= 11'd0;
               rsp_out_data_ff    <= req_data;
               rsp_request_len_ff <= req_plen;
            end
         end else if (done && out_free) begin
            busy_ff            <= 1'b0;
            rsp_kind_ff        <= 1'b0;
            rsp_frame_id_ff    <= cfg.reply_id;
            rsp_out_data_ff    <= frame_merge;
            rsp_request_len_ff <= 3'd0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_frame_id    = rsp_frame_id_ff;
   assign rsp_out_data    = rsp_out_data_ff;
   assign rsp_request_len = rsp_request_len_ff;

endmodule

`default_nettype wire

/* src/isotp_segmented_sender_checker.sv */
// Port-level assertions for isotp_segmented_sender_top and the bind that attaches them.
// Depends only on the top level's ports.
`default_nettype none

module isotp_segmented_sender_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_kind,
   input wire logic [10:0] rsp_frame_id,
   input wire logic [63:0] rsp_out_data,
   input wire logic [2:0]  rsp_request_len
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_data)
                                    && $stable(rsp_kind) && $stable(rsp_frame_id)
                                    && $stable(rsp_request_len)))
      else $error("Stalled response word changed.");

   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("Response valid right after reset.");

   a_request_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind) |-> (rsp_frame_id == 11'd0 && rsp_out_data[63:56] == 8'd0))
      else $error("Delivered request carries an id or an eighth byte.");

   a_empty_request: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind && rsp_request_len == 3'd0) |-> (rsp_out_data == 64'd0))
      else $error("Empty request carries payload bytes.");

   a_frame_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_kind) |-> (rsp_request_len == 3'd0))
      else $error("Transmitted frame carries a request length.");

endmodule

bind isotp_segmented_sender_top isotp_segmented_sender_checker u_checker (.*);

`default_nettype wire
